// ===== rtl/bdte_pkg.sv =====
// bdte_pkg.sv: constants, calendar tables and helpers for the date to epoch converter
`timescale 1ns / 1ps

package bdte_pkg;

  // stream payload widths, whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 96;

  // divide-by-constant unit: operand biased to a positive value below 2**23
  localparam int DIV_OFF_W  = 23;
  localparam int DIV_RCP_W  = 21;
  localparam int DIV_PROD_W = DIV_OFF_W + DIV_RCP_W;
  localparam int DIV_Q_W    = DIV_PROD_W - DIV_OFF_W;
  localparam int DIV_BIAS   = 3780000;  // multiple of 60, 24, 12 and 7

  // reciprocals floor(2**23 / d)
  localparam logic [DIV_RCP_W-1:0] RCP_60 = DIV_RCP_W'(139810);
  localparam logic [DIV_RCP_W-1:0] RCP_24 = DIV_RCP_W'(349525);
  localparam logic [DIV_RCP_W-1:0] RCP_12 = DIV_RCP_W'(699050);
  localparam logic [DIV_RCP_W-1:0] RCP_7  = DIV_RCP_W'(1198372);

  // bias expressed in quotient units, DIV_BIAS / d
  localparam logic [DIV_Q_W-1:0] QB_60 = DIV_Q_W'(DIV_BIAS / 60);
  localparam logic [DIV_Q_W-1:0] QB_24 = DIV_Q_W'(DIV_BIAS / 24);
  localparam logic [DIV_Q_W-1:0] QB_12 = DIV_Q_W'(DIV_BIAS / 12);
  localparam logic [DIV_Q_W-1:0] QB_7  = DIV_Q_W'(DIV_BIAS / 7);

  // four julian years always hold this many days, whatever the start month
  localparam logic signed [16:0] QUAD_DAYS = 17'sd1461;

  // days from 1900-01-01 to 1970-01-01
  localparam int EPOCH_DAY_OFS = 25568;

  // years since 1900 beyond this are flagged
  localparam logic signed [17:0] YEAR_LIMIT = 18'sd10000;

  // bias a signed operand into the divider range
  function automatic logic [DIV_OFF_W-1:0] div_load(input logic signed [23:0] x);
    return DIV_OFF_W'(x + DIV_BIAS);
  endfunction

  // month length, month 0 is january
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m, common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/broken_down_time_to_epoch.sv =====
// broken_down_time_to_epoch.sv: broken-down date and time to seconds since 1970
`timescale 1ns / 1ps

// channel  dir  signals                        contents
// -------  ---  -----------------------------  ---------------------------------------
// input    in   s_tvalid s_tready s_tdata      second minute hour day month year
// output   out  m_tvalid m_tready m_tdata      epoch, normalized fields, yday, weekday
//                          m_tuser             out of range flag
//
// one item at a time; s_tready is high only while the sequencer is idle
// a calendar carry step moves four years while the day is over 1461 out, else one month
// the shared biased reciprocal divider (multiply, remainder, fix) runs five times
// a finished item waits in the output register; the next item may enter meanwhile
// rst is synchronous and clears the sequencer and m_tvalid only

module broken_down_time_to_epoch
  import bdte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // second_in[15:0] minute_in[31:16] hour_in[47:32] day_in[63:48]
  // month_in[71:64] year_in[86:72], zero pad[87]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // epoch_seconds[39:0] second_out[45:40] minute_out[51:46] hour_out[56:52]
  // day_out[61:57] month_out[65:62] year_out[80:66] year_day[89:81]
  // week_day[92:90], zero pad[95:93]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // out_of_range[0]
  output logic                  m_tuser
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DV_MUL, ST_DV_REM, ST_DV_FIX, ST_CARRY,
    ST_YDAY, ST_DAYS, ST_EPOCH, ST_FINISH
  } state_t;

  // which field the divider is normalizing
  typedef enum logic [2:0] {T_SEC, T_MIN, T_HOUR, T_MON, T_WDAY} target_t;

  // one calendar carry step
  typedef enum logic [2:0] {C_BACK4, C_BACK1, C_FWD4, C_FWD1, C_DONE} carry_t;

  state_t  state;
  target_t target;

  // working fields
  logic signed [16:0] sec, minute, hour, day;
  logic signed [7:0]  mon;
  logic signed [17:0] year;
  logic        [8:0]  yday;
  logic               oor;
  logic signed [23:0] ydays, days;
  logic        [2:0]  wday;
  logic signed [39:0] eprod;
  logic        [16:0] tod;

  // divider registers
  logic [DIV_OFF_W-1:0]  div_off;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [DIV_Q_W-1:0]    div_q;
  logic [7:0]            div_r;

  // divider constants by target
  logic [6:0]           div_d;
  logic [DIV_RCP_W-1:0] div_m;
  logic [DIV_Q_W-1:0]   div_qb;

  always_comb begin
    unique case (target)
      T_SEC, T_MIN: begin div_d = 7'd60; div_m = RCP_60; div_qb = QB_60; end
      T_HOUR:       begin div_d = 7'd24; div_m = RCP_24; div_qb = QB_24; end
      T_MON:        begin div_d = 7'd12; div_m = RCP_12; div_qb = QB_12; end
      T_WDAY:       begin div_d = 7'd7;  div_m = RCP_7;  div_qb = QB_7;  end
      default:      begin div_d = 7'd60; div_m = RCP_60; div_qb = QB_60; end
    endcase
  end

  // quotient estimate is exact or one low; remainder before correction
  logic [DIV_Q_W-1:0]   q_est;
  logic [27:0]          q_times_d;
  logic [DIV_OFF_W-1:0] r_wide;

  assign q_est     = div_prod[DIV_PROD_W-1:DIV_OFF_W];
  assign q_times_d = q_est * div_d;
  assign r_wide    = div_off - q_times_d[DIV_OFF_W-1:0];

  // correction and removal of the bias
  logic                 fix;
  logic [DIV_Q_W-1:0]   q_fix;
  logic [7:0]           r_fix;
  logic signed [21:0]   qs;
  logic signed [16:0]   qs17;

  assign fix   = (div_r >= {1'b0, div_d});
  assign q_fix = div_q + DIV_Q_W'(fix);
  assign r_fix = fix ? (div_r - {1'b0, div_d}) : div_r;
  assign qs    = signed'({1'b0, q_fix}) - signed'({1'b0, div_qb});
  assign qs17  = qs[16:0];

  // carried sums into the next larger unit
  logic signed [16:0] minute_sum, hour_sum, day_sum;
  logic signed [17:0] year_sum;

  assign minute_sum = minute + qs17;
  assign hour_sum   = hour + qs17;
  assign day_sum    = day + qs17;
  assign year_sum   = year + 18'(qs);

  // calendar carry: pick one step and one day addend
  logic [3:0]         m_cur, m_prev;
  logic signed [17:0] y_prev;
  logic [4:0]         len_cur, len_prev;
  carry_t             carry;
  logic signed [16:0] day_add;

  assign m_cur    = mon[3:0];
  assign m_prev   = (m_cur == 4'd0) ? 4'd11 : m_cur - 4'd1;
  assign y_prev   = (m_cur == 4'd0) ? year - 18'sd1 : year;
  assign len_cur  = days_in(m_cur, year[1:0] == 2'b00);
  assign len_prev = days_in(m_prev, y_prev[1:0] == 2'b00);

  always_comb begin
    day_add = '0;
    priority if (day <= -QUAD_DAYS) begin
      carry   = C_BACK4;
      day_add = QUAD_DAYS;
    end else if (day < 17'sd1) begin
      carry   = C_BACK1;
      day_add = signed'({12'b0, len_prev});
    end else if (day > QUAD_DAYS) begin
      carry   = C_FWD4;
      day_add = -QUAD_DAYS;
    end else if (day > signed'({12'b0, len_cur})) begin
      carry   = C_FWD1;
      day_add = -signed'({12'b0, len_cur});
    end else begin
      carry   = C_DONE;
    end
  end

  // day of year, days since 1970 and the final sum
  logic [8:0]         yday_c;
  logic signed [23:0] days_c;
  logic signed [39:0] epoch_c;

  assign yday_c  = 9'(day[4:0]) - 9'd1 + days_before(m_cur)
                   + 9'((m_cur > 4'd1) && (year[1:0] == 2'b00));
  assign days_c  = ydays + signed'({15'b0, yday});
  assign epoch_c = oor ? 40'sd0 : eprod + signed'({23'b0, tod});

  assign s_tready = (state == ST_IDLE);

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sec     <= {s_tdata[15], s_tdata[15:0]};
            minute  <= {s_tdata[31], s_tdata[31:16]};
            hour    <= {s_tdata[47], s_tdata[47:32]};
            day     <= {s_tdata[63], s_tdata[63:48]};
            mon     <= s_tdata[71:64];
            year    <= {{3{s_tdata[86]}}, s_tdata[86:72]};
            div_off <= div_load({{8{s_tdata[15]}}, s_tdata[15:0]});
            target  <= T_SEC;
            state   <= ST_DV_MUL;
          end
        end
        ST_DV_MUL: begin
          div_prod <= div_off * div_m;
          state    <= ST_DV_REM;
        end
        ST_DV_REM: begin
          div_q <= q_est;
          div_r <= r_wide[7:0];
          state <= ST_DV_FIX;
        end
        ST_DV_FIX: begin
          unique case (target)
            T_SEC: begin
              sec     <= signed'({9'b0, r_fix});
              minute  <= minute_sum;
              div_off <= div_load(24'(minute_sum));
              target  <= T_MIN;
              state   <= ST_DV_MUL;
            end
            T_MIN: begin
              minute  <= signed'({9'b0, r_fix});
              hour    <= hour_sum;
              div_off <= div_load(24'(hour_sum));
              target  <= T_HOUR;
              state   <= ST_DV_MUL;
            end
            T_HOUR: begin
              hour    <= signed'({9'b0, r_fix});
              day     <= day_sum;
              div_off <= div_load(24'(mon));
              target  <= T_MON;
              state   <= ST_DV_MUL;
            end
            T_MON: begin
              mon   <= signed'(r_fix);
              year  <= year_sum;
              state <= ST_CARRY;
            end
            T_WDAY: begin
              wday  <= r_fix[2:0];
              state <= ST_EPOCH;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_CARRY: begin
          day <= day + day_add;
          unique case (carry)
            C_BACK4: year <= year - 18'sd4;
            C_BACK1: begin
              mon  <= signed'({4'b0, m_prev});
              year <= y_prev;
            end
            C_FWD4:  year <= year + 18'sd4;
            C_FWD1: begin
              if (m_cur == 4'd11) begin
                mon  <= '0;
                year <= year + 18'sd1;
              end else begin
                mon <= signed'({4'b0, m_cur + 4'd1});
              end
            end
            C_DONE:  state <= ST_YDAY;
            default: state <= ST_YDAY;
          endcase
        end
        ST_YDAY: begin
          yday  <= yday_c;
          oor   <= (year > YEAR_LIMIT) || (year < -YEAR_LIMIT);
          ydays <= 24'(365 * year + ((year + 18'sd3) >>> 2) - EPOCH_DAY_OFS);
          state <= ST_DAYS;
        end
        ST_DAYS: begin
          days    <= days_c;
          div_off <= div_load(days_c + 24'sd4);
          target  <= T_WDAY;
          state   <= ST_DV_MUL;
        end
        ST_EPOCH: begin
          eprod <= 40'(40'(days) * 40'sd86400);
          tod   <= 17'(hour * 3600 + minute * 60 + sec);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, (oor ? 3'd0 : wday), yday, year[14:0], mon[3:0],
                         day[4:0], hour[4:0], minute[5:0], sec[5:0], epoch_c};
            m_tuser  <= oor;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // corrected remainder always lies below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DV_FIX) |-> (r_fix < {1'b0, div_d}))
    else $error("divider remainder out of range");

  // month stays normalized through the calendar carry
  a_carry_mon: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CARRY) |-> (mon[7:4] == 4'd0) && (mon[3:0] < 4'd12))
    else $error("month out of range during carry");

  // a shown item has a real day, month and weekday
  a_out_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[61:57] != 5'd0) && (m_tdata[65:62] < 4'd12)
                 && (m_tdata[92:90] < 3'd7))
    else $error("output fields out of range");

  // a finished item reaches the output and frees the input side
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && (!m_tvalid || m_tready) |=> m_tvalid && s_tready)
    else $error("finished item not delivered");
`endif

endmodule

// ===== dv/tb_top.sv =====
// tb_top.sv: stream testbench for the broken-down time to epoch converter
`timescale 1ns / 1ps

module tb_top;
  import bdte_pkg::*;

  // one input item, signed calendar fields
  typedef struct {
    logic signed [15:0] sec;
    logic signed [15:0] minute;
    logic signed [15:0] hour;
    logic signed [15:0] mday;
    logic signed [7:0]  mon;
    logic signed [14:0] year;
  } date_fields_t;

  // one result item, fields at the block's widths
  typedef struct {
    logic [39:0] epoch;
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  mon;
    logic [14:0] year;
    logic [8:0]  yday;
    logic [2:0]  wday;
    logic        oor;
  } epoch_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  epoch_result_t pending_epochs[$];
  int            mismatch_count = 0;
  bit            no_idle = 1'b0;

  broken_down_time_to_epoch dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // integer helpers with floor semantics
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint floor_mod(input longint a, input longint b);
    return a - floor_div(a, b) * b;
  endfunction

  // julian month length, month 0 is january
  function automatic longint month_days(input longint m, input longint y);
    if (m == 1) return (floor_mod(y, 4) == 0) ? 29 : 28;
    case (m)
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // days before the first of month m in a common year
  function automatic longint days_ahead_of_month(input longint m);
    case (m)
      0:       return 0;
      1:       return 31;
      2:       return 59;
      3:       return 90;
      4:       return 120;
      5:       return 151;
      6:       return 181;
      7:       return 212;
      8:       return 243;
      9:       return 273;
      10:      return 304;
      default: return 334;
    endcase
  endfunction

  // days from 1900-01-01 to the first day of year y
  function automatic longint year_start_day(input longint y);
    return 365 * y + floor_div(y + 3, 4);
  endfunction

  // normalize the fields and count seconds since 1970
  function automatic epoch_result_t predict_epoch(input date_fields_t d);
    longint s, mi, h, dy, mo, yr, yd, days, ep, wd;
    bit oor;
    epoch_result_t r;
    s  = d.sec;
    mi = d.minute;
    h  = d.hour;
    dy = d.mday;
    mo = d.mon;
    yr = d.year;
    mi += floor_div(s, 60);
    s   = floor_mod(s, 60);
    h  += floor_div(mi, 60);
    mi  = floor_mod(mi, 60);
    dy += floor_div(h, 24);
    h   = floor_mod(h, 24);
    yr += floor_div(mo, 12);
    mo  = floor_mod(mo, 12);
    // borrow whole months while the day is not positive
    while (dy < 1) begin
      mo--;
      if (mo < 0) begin
        mo = 11;
        yr--;
      end
      dy += month_days(mo, yr);
    end
    // carry whole months while the day is past the month end
    while (dy > month_days(mo, yr)) begin
      dy -= month_days(mo, yr);
      mo++;
      if (mo > 11) begin
        mo = 0;
        yr++;
      end
    end
    yd = dy - 1 + days_ahead_of_month(mo);
    if (mo > 1 && floor_mod(yr, 4) == 0) yd++;
    oor = (yr > 10000 || yr < -10000);
    ep = 0;
    wd = 0;
    if (!oor) begin
      days = year_start_day(yr) - year_start_day(70) + yd;
      wd = floor_mod(days + 4, 7);
      ep = days * 86400 + h * 3600 + mi * 60 + s;
    end
    r.epoch  = 40'(ep);
    r.sec    = 6'(s);
    r.minute = 6'(mi);
    r.hour   = 5'(h);
    r.mday   = 5'(dy);
    r.mon    = 4'(mo);
    r.year   = 15'(yr);
    r.yday   = 9'(yd);
    r.wday   = 3'(wd);
    r.oor    = oor;
    return r;
  endfunction

  function automatic date_fields_t make_date(input int s, input int mi, input int h,
                                             input int dy, input int mo, input int yr);
    date_fields_t d;
    d.sec    = 16'(s);
    d.minute = 16'(mi);
    d.hour   = 16'(h);
    d.mday   = 16'(dy);
    d.mon    = 8'(mo);
    d.year   = 15'(yr);
    return d;
  endfunction

  // mostly valid dates, some full range noise, some near the year limits
  function automatic date_fields_t random_date();
    int pick;
    int yr;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      yr = int'($urandom_range(0, 20000)) - 10000;
      return make_date($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                       $urandom_range(1, 31), $urandom_range(0, 11), yr);
    end else if (pick < 80) begin
      return make_date($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom());
    end else begin
      yr = int'($urandom_range(0, 40)) + 9980;
      if ($urandom_range(0, 1) == 1) yr = -yr;
      return make_date(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                       int'($urandom_range(0, 100)) - 50, int'($urandom_range(0, 800)) - 400,
                       int'($urandom_range(0, 60)) - 30, yr);
    end
  endfunction

  // drive one item, wait for the handshake, then queue its prediction
  task automatic send_date(input date_fields_t d);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, d.year, d.mon, d.mday, d.hour, d.minute, d.sec};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_epochs.push_back(predict_epoch(d));
  endtask

  task automatic check_field(input string name, input logic [39:0] exp_val,
                             input logic [39:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // output side stalls
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    epoch_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_epochs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
        mismatch_count++;
      end else begin
        e = pending_epochs.pop_front();
        check_field("epoch_seconds", e.epoch, m_tdata[39:0]);
        check_field("second_out", e.sec, m_tdata[45:40]);
        check_field("minute_out", e.minute, m_tdata[51:46]);
        check_field("hour_out", e.hour, m_tdata[56:52]);
        check_field("day_out", e.mday, m_tdata[61:57]);
        check_field("month_out", e.mon, m_tdata[65:62]);
        check_field("year_out", e.year, m_tdata[80:66]);
        check_field("year_day", e.yday, m_tdata[89:81]);
        check_field("week_day", e.wday, m_tdata[92:90]);
        check_field("out_of_range", e.oor, m_tuser);
      end
    end
  end

  // field extremes, borrow and carry cases, leap days, year limits and wrap
  task automatic test_calendar_corners();
    send_date(make_date(0, 0, 0, 1, 0, 70));
    send_date(make_date(-1, 0, 0, 1, 0, 70));
    send_date(make_date(0, 0, 0, 0, 0, 0));
    send_date(make_date(0, 0, 0, -365, 0, 1));
    send_date(make_date(59, 59, 23, 31, 11, 10000));
    send_date(make_date(0, 0, 0, 1, 0, -10000));
    send_date(make_date(0, 0, 0, 32, 11, 10000));
    send_date(make_date(-1, 0, 0, 1, 0, -10000));
    send_date(make_date(0, 0, 0, 29, 1, 72));
    send_date(make_date(0, 0, 0, 29, 1, 73));
    send_date(make_date(0, 0, 0, 31, 11, 72));
    send_date(make_date(0, 0, 0, 1, -1, 70));
    send_date(make_date(0, 0, 0, 1, -128, 100));
    send_date(make_date(0, 0, 0, 1, 127, 100));
    send_date(make_date(32767, 32767, 32767, 32767, 127, 16383));
    send_date(make_date(-32768, -32768, -32768, -32768, -128, -16384));
    send_date(make_date(0, 0, 0, 1, 0, 16383));
    send_date(make_date(0, 0, 0, 1, 0, -16384));
    send_date(make_date(32767, 32767, 32767, 32767, 0, 0));
    send_date(make_date(-32768, -32768, -32768, -32768, -128, 0));
    send_date(make_date(0, 0, 0, 1, 127, 16383));
    send_date(make_date(0, 0, 0, 1, -128, -16384));
    send_date(make_date(60, 60, 24, 32, 12, 99));
  endtask

  // random dates with idling on both sides
  task automatic test_random_dates(input int count);
    repeat (count) send_date(random_date());
  endtask

  // random dates with neither side idling
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) send_date(random_date());
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_calendar_corners();
    test_random_dates(700);
    test_back_to_back(300);
    test_random_dates(330);
    s_tvalid <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
